// ===== hw/rtl/snake_order_index_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Snake order index generator assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SNAKE_ORDER_INDEX_GENERATOR_DEFINES_SVH
`define SNAKE_ORDER_INDEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SOIG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("soig: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SOIG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("soig: next-cycle check failed");

`endif

// ===== hw/rtl/soig_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snake order index generator package
// Widths, register indexes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package soig_pkg;

    // Grid geometry.
    localparam int AXES     = 4;   // axes supported
    localparam int AX_W     = 2;   // axis index width
    localparam int NAX_W    = 3;   // axis count width
    localparam int SIZE_W   = 13;  // axis size register width
    localparam int DIG_W    = 12;  // per-axis index width
    localparam int POS_W    = 49;  // position counter and element total width
    localparam int VAL_W    = 48;  // jump value and flat index width

    // Shared multiplier splits a wide operand into a low and a high part.
    localparam int LO_W     = 25;
    localparam int PROD_W   = LO_W + SIZE_W;
    localparam int WIDE_W   = PROD_W + LO_W;

    // Restoring division steps per axis.
    localparam int BIT_W    = 4;
    localparam int DIV_TOP  = DIG_W - 1;

    // Stream widths.
    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 152;
    localparam int OUT_PAD_W  = OUT_DATA_W - VAL_W - AXES * DIG_W - POS_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS0_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS1_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS2_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS3_SIZE = 3'd4;

    // Operation carried with each input transaction.
    typedef enum logic [1:0] {
        MODE_ADVANCE = 2'd0,
        MODE_RESTART = 2'd1,
        MODE_JUMP    = 2'd2
    } t_mode;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIDE,
        ST_DECIDE,
        ST_DIV,
        ST_FLAT,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/snake_order_index_generator.sv =====
`timescale 1ns / 1ps
// Input is accepted only in the idle state, so one transaction is processed at a time;
// one shared multiply-add/subtract unit carries the stride, division and flat-index steps.
// Reset (synchronous, active low): axis count and sizes to 1, position to zero.
// ----------------------------------------------------------------------------
// Snake order index generator
// Walks a grid of up to four axes in boustrophedon order. A small sequencer
// drives one shared multiplier and adder through stride products, digit
// division where needed and the flat-index sum for every input transaction.
// ----------------------------------------------------------------------------
`include "snake_order_index_generator_defines.svh"

module snake_order_index_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [soig_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [soig_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: counter_value[47:0]
    input  logic [soig_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [soig_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    // Output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: snake_flat_index[47:0], snake_axis0[59:48], snake_axis1[71:60],
    //        snake_axis2[83:72], snake_axis3[95:84], element_total[144:96], zero pad
    output logic [soig_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // tuser: done_res[0]
    output logic                                o_m_axis_tuser
);

    localparam int AXES   = soig_pkg::AXES;
    localparam int AX_W   = soig_pkg::AX_W;
    localparam int NAX_W  = soig_pkg::NAX_W;
    localparam int SIZE_W = soig_pkg::SIZE_W;
    localparam int DIG_W  = soig_pkg::DIG_W;
    localparam int POS_W  = soig_pkg::POS_W;
    localparam int VAL_W  = soig_pkg::VAL_W;
    localparam int LO_W   = soig_pkg::LO_W;
    localparam int PROD_W = soig_pkg::PROD_W;
    localparam int WIDE_W = soig_pkg::WIDE_W;
    localparam int BIT_W  = soig_pkg::BIT_W;

    // Control and architectural state.
    soig_pkg::t_state       r_state, n_state;
    logic [NAX_W-1:0]       r_axis_count;
    logic [SIZE_W-1:0]      r_axis_size [AXES];
    logic [POS_W-1:0]       r_cnt;
    logic [DIG_W-1:0]       r_dig [AXES];
    logic                   r_fin;
    logic                   r_dig_ok;
    logic [AX_W-1:0]        r_axis;
    logic                   r_half;
    logic [BIT_W-1:0]       r_bit;
    logic                   r_out_valid;

    // Working registers of the current transaction.
    soig_pkg::t_mode        r_mode;
    logic [VAL_W-1:0]       r_value;
    logic [POS_W-1:0]       r_stride [AXES];
    logic [POS_W-1:0]       r_total;
    logic [POS_W-1:0]       r_acc;
    logic [POS_W-1:0]       r_rem;
    logic [POS_W-1:0]       r_dvs;

    // Output register.
    logic [VAL_W-1:0]       r_out_flat;
    logic [DIG_W-1:0]       r_out_axis [AXES];
    logic                   r_out_done;
    logic [POS_W-1:0]       r_out_total;

    // Combinational signals.
    logic [NAX_W-1:0]       w_used;
    logic [AX_W-1:0]        w_last_axis;
    logic [SIZE_W-1:0]      w_size [AXES];
    logic [DIG_W-1:0]       w_snake [AXES];
    logic [DIG_W-1:0]       w_inc_dig [AXES];
    logic [AX_W-1:0]        w_sidx;
    logic [POS_W-1:0]       w_stride_rd;
    logic [LO_W-1:0]        w_mul_a;
    logic [SIZE_W-1:0]      w_mul_b;
    logic [PROD_W-1:0]      w_prod;
    logic [WIDE_W-1:0]      w_prod_wide;
    logic [POS_W-1:0]       w_add_x;
    logic [POS_W-1:0]       w_add_y;
    logic                   w_sub;
    logic [POS_W:0]         w_sum;
    logic [POS_W-1:0]       w_cnt_inc;
    logic                   w_cnt_lt;
    logic                   w_inc_end;
    logic                   w_val_ge;
    logic                   w_axis_last;
    logic                   w_start_div;
    logic                   w_out_load;

    // Clamp the axis count and sizes to their legal ranges.
    always_comb begin
        if (r_axis_count == '0) begin
            w_used = NAX_W'(1);
        end else if (r_axis_count > NAX_W'(AXES)) begin
            w_used = NAX_W'(AXES);
        end else begin
            w_used = r_axis_count;
        end
        for (int k = 0; k < AXES; k++) begin
            if (r_axis_size[k] == '0) begin
                w_size[k] = SIZE_W'(1);
            end else if (r_axis_size[k] > (SIZE_W'(1) << DIG_W)) begin
                w_size[k] = SIZE_W'(1) << DIG_W;
            end else begin
                w_size[k] = r_axis_size[k];
            end
        end
    end

    assign w_last_axis = AX_W'(w_used - NAX_W'(1));
    assign w_axis_last = (({1'b0, r_axis} + NAX_W'(1)) == w_used);

    // Snake mapping: later axes mirror when the earlier snake indices sum to odd.
    always_comb begin
        logic           par;
        logic [DIG_W-1:0] dd;
        par = 1'b0;
        for (int k = 0; k < AXES; k++) begin
            dd = r_dig[k];
            if ({1'b0, dd} >= w_size[k]) begin
                dd = DIG_W'(w_size[k] - SIZE_W'(1));
            end
            if (k > 0 && par) begin
                dd = DIG_W'(w_size[k] - SIZE_W'(1) - {1'b0, dd});
            end
            if (k < int'(w_used)) begin
                w_snake[k] = dd;
                par        = par ^ dd[0];
            end else begin
                w_snake[k] = '0;
            end
        end
    end

    // Mixed-radix increment of the held digits, fastest axis first.
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int k = AXES - 1; k >= 0; k--) begin
            w_inc_dig[k] = r_dig[k];
            if (k < int'(w_used) && carry) begin
                if (({1'b0, r_dig[k]} + SIZE_W'(1)) == w_size[k]) begin
                    w_inc_dig[k] = '0;
                end else begin
                    w_inc_dig[k] = r_dig[k] + DIG_W'(1);
                    carry        = 1'b0;
                end
            end
        end
    end

    // Stride table read port: the next axis is fetched on the last division step.
    assign w_sidx      = (r_state == soig_pkg::ST_DIV && r_bit == '0) ?
                         AX_W'(r_axis + AX_W'(1)) : r_axis;
    assign w_stride_rd = r_stride[w_sidx];

    // Shared unit: one multiplier on half the stride, one adder/subtractor.
    assign w_mul_a     = r_half ? LO_W'(w_stride_rd[POS_W-1:LO_W]) : w_stride_rd[LO_W-1:0];
    assign w_mul_b     = (r_state == soig_pkg::ST_STRIDE) ? w_size[r_axis]
                                                          : {1'b0, w_snake[r_axis]};
    assign w_prod      = w_mul_a * w_mul_b;
    assign w_prod_wide = {w_prod, {LO_W{1'b0}}};

    always_comb begin
        if (r_state == soig_pkg::ST_DIV) begin
            w_add_x = r_rem;
            w_add_y = r_dvs;
            w_sub   = 1'b1;
        end else begin
            w_add_x = (r_state == soig_pkg::ST_STRIDE && !r_half) ? '0 : r_acc;
            w_add_y = r_half ? w_prod_wide[POS_W-1:0] : POS_W'(w_prod);
            w_sub   = 1'b0;
        end
    end

    assign w_sum = {1'b0, w_add_x} + {1'b0, w_add_y ^ {POS_W{w_sub}}} + (POS_W + 1)'(w_sub);

    // Position checks used when the operation is applied.
    assign w_cnt_inc = r_cnt + POS_W'(1);
    assign w_cnt_lt  = (r_cnt < r_total);
    assign w_inc_end = (w_cnt_inc == r_total);
    assign w_val_ge  = ({1'b0, r_value} >= r_total);

    // Next state and handshake outputs.
    always_comb begin
        n_state     = r_state;
        w_start_div = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            soig_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = soig_pkg::ST_STRIDE;
                end
            end
            soig_pkg::ST_STRIDE: begin
                if (r_half && r_axis == '0) begin
                    n_state = soig_pkg::ST_DECIDE;
                end
            end
            soig_pkg::ST_DECIDE: begin
                unique case (r_mode)
                    soig_pkg::MODE_ADVANCE: w_start_div = w_cnt_lt && !w_inc_end && !r_dig_ok;
                    soig_pkg::MODE_JUMP:    w_start_div = !w_val_ge;
                    default:                w_start_div = 1'b0;
                endcase
                n_state = w_start_div ? soig_pkg::ST_DIV : soig_pkg::ST_FLAT;
            end
            soig_pkg::ST_DIV: begin
                if (r_bit == '0 && w_axis_last) begin
                    n_state = soig_pkg::ST_FLAT;
                end
            end
            soig_pkg::ST_FLAT: begin
                if (r_half && w_axis_last) begin
                    n_state = soig_pkg::ST_OUT;
                end
            end
            soig_pkg::ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = soig_pkg::ST_IDLE;
                end
            end
            default: n_state = soig_pkg::ST_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == soig_pkg::ST_IDLE);

    // State register, configuration and position state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= soig_pkg::ST_IDLE;
            r_axis_count <= NAX_W'(1);
            for (int k = 0; k < AXES; k++) begin
                r_axis_size[k] <= SIZE_W'(1);
                r_dig[k]       <= '0;
            end
            r_cnt       <= '0;
            r_fin       <= 1'b0;
            r_dig_ok    <= 1'b1;
            r_axis      <= '0;
            r_half      <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            unique case (r_state)
                soig_pkg::ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_axis <= w_last_axis;
                        r_half <= 1'b0;
                    end
                end
                soig_pkg::ST_STRIDE: begin
                    r_half <= !r_half;
                    if (r_half && r_axis != '0) begin
                        r_axis <= r_axis - AX_W'(1);
                    end
                end
                soig_pkg::ST_DECIDE: begin
                    r_axis <= '0;
                    r_half <= 1'b0;
                    r_bit  <= BIT_W'(soig_pkg::DIV_TOP);
                    unique case (r_mode)
                        soig_pkg::MODE_ADVANCE: begin
                            if (w_cnt_lt) begin
                                if (w_inc_end) begin
                                    r_cnt    <= r_total;
                                    r_fin    <= 1'b1;
                                    r_dig_ok <= 1'b0;
                                end else begin
                                    r_cnt    <= w_cnt_inc;
                                    r_fin    <= 1'b0;
                                    r_dig_ok <= 1'b1;
                                    if (r_dig_ok) begin
                                        r_dig <= w_inc_dig;
                                    end
                                end
                            end else begin
                                r_fin <= 1'b1;
                            end
                        end
                        soig_pkg::MODE_RESTART: begin
                            r_cnt    <= '0;
                            r_fin    <= 1'b0;
                            r_dig_ok <= 1'b1;
                            for (int k = 0; k < AXES; k++) begin
                                r_dig[k] <= '0;
                            end
                        end
                        soig_pkg::MODE_JUMP: begin
                            r_cnt    <= {1'b0, r_value};
                            r_fin    <= w_val_ge;
                            r_dig_ok <= !w_val_ge;
                        end
                        default: begin
                        end
                    endcase
                    // A new split leaves the axes not in use at zero.
                    if (w_start_div) begin
                        for (int k = 0; k < AXES; k++) begin
                            if (k >= int'(w_used)) begin
                                r_dig[k] <= '0;
                            end
                        end
                    end
                end
                soig_pkg::ST_DIV: begin
                    r_dig[r_axis] <= {r_dig[r_axis][DIG_W-2:0], w_sum[POS_W]};
                    r_bit         <= r_bit - BIT_W'(1);
                    if (r_bit == '0) begin
                        r_bit  <= BIT_W'(soig_pkg::DIV_TOP);
                        r_axis <= w_axis_last ? '0 : AX_W'(r_axis + AX_W'(1));
                        r_half <= 1'b0;
                    end
                end
                soig_pkg::ST_FLAT: begin
                    r_half <= !r_half;
                    if (r_half) begin
                        r_axis <= AX_W'(r_axis + AX_W'(1));
                    end
                end
                soig_pkg::ST_OUT: begin
                end
                default: begin
                end
            endcase

            // Output valid holds until the downstream side takes the transaction.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes must come only while idle (the user's duty, not enforced); held digits go stale.
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    soig_pkg::CFG_AXIS_COUNT: begin
                        r_axis_count <= i_cfg_wdata[NAX_W-1:0];
                        r_dig_ok     <= 1'b0;
                    end
                    soig_pkg::CFG_AXIS0_SIZE: begin
                        r_axis_size[0] <= i_cfg_wdata;
                        r_dig_ok       <= 1'b0;
                    end
                    soig_pkg::CFG_AXIS1_SIZE: begin
                        r_axis_size[1] <= i_cfg_wdata;
                        r_dig_ok       <= 1'b0;
                    end
                    soig_pkg::CFG_AXIS2_SIZE: begin
                        r_axis_size[2] <= i_cfg_wdata;
                        r_dig_ok       <= 1'b0;
                    end
                    soig_pkg::CFG_AXIS3_SIZE: begin
                        r_axis_size[3] <= i_cfg_wdata;
                        r_dig_ok       <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers of the shared unit and the output register.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            soig_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    r_mode                <= soig_pkg::t_mode'(i_s_axis_tuser);
                    r_value               <= i_s_axis_tdata[VAL_W-1:0];
                    r_stride[w_last_axis] <= POS_W'(1);
                end
            end
            soig_pkg::ST_STRIDE: begin
                // Stride of the next slower axis, or the element total after axis 0.
                r_acc <= w_sum[POS_W-1:0];
                if (r_half) begin
                    if (r_axis == '0) begin
                        r_total <= w_sum[POS_W-1:0];
                    end else begin
                        r_stride[r_axis - AX_W'(1)] <= w_sum[POS_W-1:0];
                    end
                end
            end
            soig_pkg::ST_DECIDE: begin
                r_acc <= '0;
                r_rem <= (r_mode == soig_pkg::MODE_JUMP) ? {1'b0, r_value} : w_cnt_inc;
                r_dvs <= w_stride_rd << soig_pkg::DIV_TOP;
            end
            soig_pkg::ST_DIV: begin
                // Restoring step: keep the difference when no borrow occurred.
                if (w_sum[POS_W]) begin
                    r_rem <= w_sum[POS_W-1:0];
                end
                if (r_bit == '0) begin
                    r_dvs <= w_stride_rd << soig_pkg::DIV_TOP;
                end else begin
                    r_dvs <= r_dvs >> 1;
                end
            end
            soig_pkg::ST_FLAT: begin
                r_acc <= w_sum[POS_W-1:0];
            end
            soig_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase

        if (w_out_load) begin
            r_out_flat  <= r_acc[VAL_W-1:0];
            r_out_axis  <= w_snake;
            r_out_done  <= r_fin;
            r_out_total <= r_total;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_done;
    assign o_m_axis_tdata  = {{soig_pkg::OUT_PAD_W{1'b0}}, r_out_total,
                              r_out_axis[3], r_out_axis[2], r_out_axis[1], r_out_axis[0],
                              r_out_flat};

    // Checks on the sequencer and the shared unit.
    `SOIG_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, r_state == soig_pkg::ST_STRIDE)
    `SOIG_ASSERT_IMPL(a_div_bound, r_state == soig_pkg::ST_DIV, (r_rem >> 1) < r_dvs)
    `SOIG_ASSERT_IMPL(a_flat_in_grid, o_m_axis_tvalid, {1'b0, r_out_flat} < r_out_total)
    `SOIG_ASSERT_IMPL(a_out_from_seq, $rose(o_m_axis_tvalid), $past(r_state) == soig_pkg::ST_OUT)

endmodule

// ===== dv/snake_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snake order checker
// Watches the configuration port and both streams of the snake order index
// generator. It keeps its own copy of the grid settings and of the walk
// position, works out the snake position for every accepted input
// transaction, and compares each output transaction field by field with the
// oldest outstanding position.
// ----------------------------------------------------------------------------
module snake_order_checker
    import soig_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration writes as seen by the block
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_DATA_W-1:0]   i_in_data,
    input  logic [IN_USER_W-1:0]   i_in_mode,
    // Output stream
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_DATA_W-1:0]  i_out_data,
    input  logic                   i_out_done,
    // Status for the testbench top
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_done_seen
);

    localparam int PRINT_CAP = 60;

    // One snake position as carried by an output transaction.
    typedef struct packed {
        logic [VAL_W-1:0]             flat;
        logic [AXES-1:0][DIG_W-1:0]   axis;
        logic                         done;
        logic [POS_W-1:0]             total;
    } t_snake_result;

    // Grid settings as last written.
    logic [NAX_W-1:0]  grid_axes;
    logic [SIZE_W-1:0] grid_size [AXES];

    // Row-major walk position, its digits and the end-of-walk flag.
    logic [POS_W-1:0]  walk_pos;
    logic [DIG_W-1:0]  walk_digit [AXES];
    logic              walk_done;

    t_snake_result     snake_positions_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_done_seen  = 0;
    end

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_error(input string msg);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        else if (o_fail_count == PRINT_CAP + 1)
            $display("[%0t] further mismatches are counted but not printed", $realtime);
    endtask

    // Axis count in use; zero acts as one and anything above the limit as the limit.
    function automatic int axes_in_use();
        int n;
        n = grid_axes;
        if (n < 1) n = 1;
        if (n > AXES) n = AXES;
        return n;
    endfunction

    // Extent of one axis, clamped into 1..2^DIG_W.
    function automatic longint unsigned extent(input int k);
        longint unsigned s;
        s = grid_size[k];
        if (s < 1) s = 1;
        if (s > (64'd1 << DIG_W)) s = 64'd1 << DIG_W;
        return s;
    endfunction

    // Splits a row-major position into per-axis digits, fastest axis last.
    task automatic load_digits(input longint unsigned pos);
        int n;
        int k;
        longint unsigned s;
        n = axes_in_use();
        for (k = n - 1; k >= 0; k--) begin
            s = extent(k);
            walk_digit[k] = DIG_W'(pos % s);
            pos = pos / s;
        end
        for (k = n; k < AXES; k++) walk_digit[k] = '0;
    endtask

    // Applies one input transaction to the walk and returns the snake position.
    task automatic step_walk(input logic [IN_USER_W-1:0] mode,
                             input logic [VAL_W-1:0] value,
                             output t_snake_result res);
        int n;
        int k;
        longint unsigned total;
        longint unsigned flat;
        longint unsigned parity;
        longint unsigned s;
        longint unsigned d;
        n = axes_in_use();
        total = 1;
        for (k = 0; k < n; k++) total = total * extent(k);

        case (mode)
            MODE_ADVANCE: begin
                // The walk stops at the total and holds the last cell.
                if (walk_pos < total) begin
                    walk_pos = walk_pos + 1'b1;
                    if (walk_pos >= total) begin
                        walk_pos  = total[POS_W-1:0];
                        walk_done = 1'b1;
                    end else begin
                        load_digits(walk_pos);
                        walk_done = 1'b0;
                    end
                end else begin
                    walk_done = 1'b1;
                end
            end
            MODE_RESTART: begin
                walk_pos  = '0;
                for (k = 0; k < AXES; k++) walk_digit[k] = '0;
                walk_done = 1'b0;
            end
            MODE_JUMP: begin
                // A jump off the grid keeps the previous digits.
                walk_pos = {1'b0, value};
                if (value >= total) begin
                    walk_done = 1'b1;
                end else begin
                    load_digits(value);
                    walk_done = 1'b0;
                end
            end
            default: begin
                // The unused code leaves the walk as it is.
            end
        endcase

        // Mirror each later axis when the earlier snake indices sum to an odd value.
        res    = '0;
        flat   = 0;
        parity = 0;
        for (k = 0; k < n; k++) begin
            s = extent(k);
            d = walk_digit[k];
            if (d >= s) d = s - 1;
            if (k > 0 && parity[0]) d = s - 1 - d;
            res.axis[k] = d[DIG_W-1:0];
            parity = parity + d;
            flat   = flat * s + d;
        end
        res.flat  = flat[VAL_W-1:0];
        res.done  = walk_done;
        res.total = total[POS_W-1:0];
    endtask

    // Compares one output transaction with the oldest outstanding position.
    task automatic check_result();
        t_snake_result want;
        t_snake_result seen;
        int k;
        seen.flat = i_out_data[VAL_W-1:0];
        for (k = 0; k < AXES; k++) seen.axis[k] = i_out_data[VAL_W + k*DIG_W +: DIG_W];
        seen.total = i_out_data[VAL_W + AXES*DIG_W +: POS_W];
        seen.done  = i_out_done;
        o_checked++;
        if (seen.done) o_done_seen++;
        if (snake_positions_q.size() == 0) begin
            report_error($sformatf("result %0d arrived with no input outstanding", o_checked));
            return;
        end
        want = snake_positions_q.pop_front();
        if (seen.flat !== want.flat)
            report_error($sformatf("result %0d snake_flat_index: expected 0x%0h, got 0x%0h",
                                   o_checked, want.flat, seen.flat));
        for (k = 0; k < AXES; k++)
            if (seen.axis[k] !== want.axis[k])
                report_error($sformatf("result %0d snake_axis%0d: expected %0d, got %0d",
                                       o_checked, k, want.axis[k], seen.axis[k]));
        if (seen.done !== want.done)
            report_error($sformatf("result %0d done_res: expected %0b, got %0b",
                                   o_checked, want.done, seen.done));
        if (seen.total !== want.total)
            report_error($sformatf("result %0d element_total: expected 0x%0h, got 0x%0h",
                                   o_checked, want.total, seen.total));
    endtask

    // Everything is sampled at the rising edge, as the block samples it.
    always @(posedge i_clk) begin
        t_snake_result next_pos;
        if (!i_rst_n) begin
            grid_axes = NAX_W'(1);
            for (int k = 0; k < AXES; k++) begin
                grid_size[k]  = SIZE_W'(1);
                walk_digit[k] = '0;
            end
            walk_pos  = '0;
            walk_done = 1'b0;
            snake_positions_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_AXIS_COUNT: grid_axes    = i_cfg_wdata[NAX_W-1:0];
                    CFG_AXIS0_SIZE: grid_size[0] = i_cfg_wdata;
                    CFG_AXIS1_SIZE: grid_size[1] = i_cfg_wdata;
                    CFG_AXIS2_SIZE: grid_size[2] = i_cfg_wdata;
                    CFG_AXIS3_SIZE: grid_size[3] = i_cfg_wdata;
                    default: begin
                        // Indexes past the register list are ignored.
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) begin
                step_walk(i_in_mode, i_in_data[VAL_W-1:0], next_pos);
                snake_positions_q.push_back(next_pos);
            end
        end
        o_pending = snake_positions_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snake order index generator testbench
// Drives the configuration port and the input stream of the generator, with
// bursty input traffic and a stalling output side. A directed opening covers
// the walk's end conditions, jumps, restarts, clamped settings and sizes
// changed mid-walk; random phases then walk grids of many shapes. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import soig_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASE_ITEMS  = 125;
    // Idle time added after the last result has drained, before the verdict.
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT   = 2000;

    localparam logic [IN_USER_W-1:0] MODE_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_AXIS3_SIZE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = {CFG_IDX_W{1'b1}};
    localparam logic [VAL_W-1:0]     VALUE_ALL_ONES  = {VAL_W{1'b1}};

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [IN_DATA_W-1:0]   in_data     = '0;
    logic [IN_USER_W-1:0]   in_mode     = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [OUT_DATA_W-1:0]  out_data;
    logic                   out_done;

    int fail_count;
    int pending;
    int checked;
    int done_seen;

    int items_sent     = 0;
    int grids_used     = 0;
    int burst_left     = 0;
    int idle_count     = 0;
    longint unsigned grid_span = 1;

    snake_order_index_generator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_mode),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_done)
    );

    snake_order_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_in_mode    (in_mode),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_out_done   (out_done),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_done_seen  (done_seen)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // The output side switches between randomly chosen stall patterns.
    int ready_cycle = 0;
    int ready_style = 0;
    always @(negedge clk) begin
        if (ready_cycle % 300 == 0) ready_style = $urandom_range(0, 3);
        case (ready_style)
            0:       out_ready = 1'b1;
            1:       out_ready = ($urandom_range(0, 3) != 0);
            2:       out_ready = ((ready_cycle % 8) < 3);
            default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
        ready_cycle++;
    end

    // Ends the run when no transaction or register write happens for too long.
    always @(posedge clk) begin
        if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one input transaction and returns at the falling edge after it is taken.
    task automatic send_item(input logic [IN_USER_W-1:0] mode, input logic [VAL_W-1:0] value);
        in_valid = 1'b1;
        in_mode  = mode;
        in_data  = value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Bursts of random length separated by random gaps, some of them empty.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Holds the input side off until every outstanding result has come back.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Writes a full grid setting once the block is idle and notes its cell count.
    task automatic apply_grid(input logic [CFG_DATA_W-1:0] axes_word,
                              input logic [CFG_DATA_W-1:0] s0, input logic [CFG_DATA_W-1:0] s1,
                              input logic [CFG_DATA_W-1:0] s2, input logic [CFG_DATA_W-1:0] s3);
        logic [CFG_DATA_W-1:0] sz [AXES];
        int n;
        longint unsigned s;
        wait_drained();
        sz[0] = s0;
        sz[1] = s1;
        sz[2] = s2;
        sz[3] = s3;
        write_reg(CFG_AXIS0_SIZE, s0);
        write_reg(CFG_AXIS1_SIZE, s1);
        write_reg($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE), $urandom);
        write_reg(CFG_AXIS2_SIZE, s2);
        write_reg(CFG_AXIS3_SIZE, s3);
        write_reg(CFG_AXIS_COUNT, axes_word);
        n = axes_word[NAX_W-1:0];
        if (n < 1) n = 1;
        if (n > AXES) n = AXES;
        grid_span = 1;
        for (int k = 0; k < n; k++) begin
            s = sz[k];
            if (s < 1) s = 1;
            if (s > (64'd1 << DIG_W)) s = 64'd1 << DIG_W;
            grid_span = grid_span * s;
        end
        grids_used++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return CFG_DATA_W'(1 << DIG_W);
        if (r == 2) return CFG_DATA_W'($urandom_range((1 << DIG_W) + 1, (1 << CFG_DATA_W) - 1));
        if (r == 3) return CFG_DATA_W'(1);
        if (r < 6)  return CFG_DATA_W'($urandom_range(1, 1 << DIG_W));
        return CFG_DATA_W'($urandom_range(2, 7));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_axes_word();
        int r;
        logic [CFG_DATA_W-1:0] w;
        r = $urandom_range(0, 9);
        w = CFG_DATA_W'($urandom);
        if (r == 0)      w[NAX_W-1:0] = '0;
        else if (r == 1) w[NAX_W-1:0] = NAX_W'($urandom_range(AXES + 1, (1 << NAX_W) - 1));
        else             w[NAX_W-1:0] = NAX_W'($urandom_range(1, AXES));
        return w;
    endfunction

    // Mostly walks forward, with restarts, jumps in and around the grid, and noise.
    task automatic send_random_item();
        int r;
        longint unsigned wide;
        wide = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 68) begin
            send_item(MODE_ADVANCE, VAL_W'(wide));
        end else if (r < 76) begin
            send_item(MODE_RESTART, VAL_W'(wide));
        end else if (r < 95) begin
            r = $urandom_range(0, 99);
            if (r < 55)      wide = wide % grid_span;
            else if (r < 80) wide = grid_span + $urandom_range(0, 5) - 3;
            send_item(MODE_JUMP, VAL_W'(wide));
        end else begin
            send_item(MODE_UNUSED, VAL_W'(wide));
        end
    endtask

    initial begin
        int random_sent;
        int j;
        random_sent = 0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single-cell grid after reset: end reached at once, held, left by jumps.
        send_item(MODE_ADVANCE, '0);
        send_item(MODE_ADVANCE, '0);
        send_item(MODE_UNUSED, '0);
        send_item(MODE_RESTART, VALUE_ALL_ONES);
        send_item(MODE_JUMP, '0);
        pace_sender();
        send_item(MODE_JUMP, VALUE_ALL_ONES);
        send_item(MODE_ADVANCE, '0);

        // Largest grid: last cell, past the end, alternating bit patterns.
        apply_grid(CFG_DATA_W'(AXES), CFG_DATA_W'(1 << DIG_W), CFG_DATA_W'(1 << DIG_W),
                   CFG_DATA_W'(1 << DIG_W), CFG_DATA_W'(1 << DIG_W));
        send_item(MODE_JUMP, VALUE_ALL_ONES);
        send_item(MODE_ADVANCE, '0);
        send_item(MODE_ADVANCE, '0);
        send_item(MODE_JUMP, 48'hAAAA_AAAA_AAAA);
        pace_sender();
        send_item(MODE_JUMP, 48'h5555_5555_5555);
        send_item(MODE_UNUSED, VALUE_ALL_ONES);
        send_item(MODE_RESTART, '0);
        send_item(MODE_ADVANCE, '0);
        send_item(MODE_ADVANCE, '0);

        // Out-of-range count and sizes, changed mid-walk so held digits get clamped.
        apply_grid(CFG_DATA_W'((1 << NAX_W) - 1), '0, CFG_DATA_W'((1 << CFG_DATA_W) - 1),
                   CFG_DATA_W'(3), CFG_DATA_W'(2));
        send_item(MODE_UNUSED, '0);
        send_item(MODE_ADVANCE, '0);
        send_item(MODE_JUMP, VAL_W'(grid_span - 1));
        send_item(MODE_ADVANCE, '0);

        // Zero axis count acts as one axis; the counter starts far past the end.
        apply_grid('0, CFG_DATA_W'(5), CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1));
        send_item(MODE_ADVANCE, '0);
        send_item(MODE_JUMP, VAL_W'(3));
        send_item(MODE_ADVANCE, '0);
        send_item(MODE_ADVANCE, '0);

        // Random phases, each on a fresh grid setting; the walk carries over.
        while (random_sent < RANDOM_ITEMS) begin
            apply_grid(pick_axes_word(), pick_size(), pick_size(), pick_size(), pick_size());
            for (j = 0; j < PHASE_ITEMS && random_sent < RANDOM_ITEMS; j++) begin
                if (j == PHASE_ITEMS / 2) wait_drained();
                send_random_item();
                random_sent++;
                pace_sender();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d input transactions over %0d grid settings; %0d results compared.",
                 items_sent, grids_used, checked);
        $display("%0d results reported the end of the walk; %0d mismatches found.",
                 done_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
